/* hdl/clet_pkg.sv */
`timescale 1ns / 1ps

package clet_pkg;

  localparam int NOW_W  = 32;
  localparam int CNT_W  = 7;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [NOW_W-1:0] OFF_DELAY_RST  = NOW_W'(1000);
  localparam logic [CNT_W-1:0] TRIP_LIMIT_RST = CNT_W'(3);
  localparam logic [CNT_W-1:0] LIMIT_LATCH    = CNT_W'(1);

  // register index, taken from paddr bit 2
  typedef enum logic {
    REG_OFF_DELAY  = 1'b0,
    REG_TRIP_LIMIT = 1'b1
  } clet_reg_t;

  typedef struct packed {
    logic [NOW_W-1:0] off_delay_ms;
    logic [CNT_W-1:0] trip_limit;
  } clet_cfg_t;

  typedef struct packed {
    logic             trip;
    logic [CNT_W-1:0] episode_count;
  } clet_result_t;

endpackage

/* hdl/clet_in_if.sv */
`timescale 1ns / 1ps

interface clet_in_if;
  logic                      valid;
  logic                      ready;
  logic                      warning;
  logic [clet_pkg::NOW_W-1:0] now_ms;

  modport source (output valid, output warning, output now_ms, input ready);
  modport sink   (input valid, input warning, input now_ms, output ready);
endinterface

/* hdl/clet_out_if.sv */
`timescale 1ns / 1ps

interface clet_out_if;
  logic                      valid;
  logic                      ready;
  logic                      trip;
  logic [clet_pkg::CNT_W-1:0] episode_count;

  modport source (output valid, output trip, output episode_count, input ready);
  modport sink   (input valid, input trip, input episode_count, output ready);
endinterface

/* hdl/clet_regs.sv */
`timescale 1ns / 1ps

module clet_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [clet_pkg::ADDR_W-1:0] paddr,
  input  logic [clet_pkg::DATA_W-1:0] pwdata,
  output logic [clet_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output clet_pkg::clet_cfg_t         cfg
);

  clet_pkg::clet_cfg_t cfg_r, cfg_nxt;
  clet_pkg::clet_reg_t sel;
  logic                wr_en;

  assign sel    = clet_pkg::clet_reg_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (sel)
        clet_pkg::REG_OFF_DELAY:  cfg_nxt.off_delay_ms = pwdata;
        clet_pkg::REG_TRIP_LIMIT: cfg_nxt.trip_limit   = pwdata[clet_pkg::CNT_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (sel)
      clet_pkg::REG_OFF_DELAY:  prdata = cfg_r.off_delay_ms;
      clet_pkg::REG_TRIP_LIMIT: prdata = clet_pkg::DATA_W'(cfg_r.trip_limit);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.off_delay_ms <= clet_pkg::OFF_DELAY_RST;
      cfg_r.trip_limit   <= clet_pkg::TRIP_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hdl/clet_core.sv */
`timescale 1ns / 1ps

module clet_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       warning,
  input  logic [clet_pkg::NOW_W-1:0] now_ms,
  input  clet_pkg::clet_cfg_t        cfg,
  output clet_pkg::clet_result_t     res
);

  logic                       edge_prev_r, edge_prev_nxt;
  logic [clet_pkg::CNT_W-1:0] episodes_r, episodes_nxt;
  logic                       tof_prev_r, tof_prev_nxt;
  logic                       tof_run_r, tof_run_nxt;
  logic [clet_pkg::NOW_W-1:0] tof_start_r, tof_start_nxt;

  logic                       latch_mode;
  logic                       fall;
  logic                       run0;
  logic [clet_pkg::NOW_W-1:0] start0;
  logic [clet_pkg::NOW_W-1:0] elapsed;
  logic                       hold;
  logic                       stretched;
  logic                       level;
  logic                       rise;
  logic [clet_pkg::CNT_W-1:0] cap;

  always_comb begin
    latch_mode = (cfg.trip_limit == clet_pkg::LIMIT_LATCH);

    // off-delay timer
    fall      = tof_prev_r && !warning;
    run0      = (fall || tof_run_r) && !warning;
    start0    = fall ? now_ms : tof_start_r;
    elapsed   = now_ms - start0;
    hold      = run0 && (elapsed <= cfg.off_delay_ms);
    stretched = warning || hold;

    // episode edge detect, raw warning in latch mode
    level = latch_mode ? warning : stretched;
    rise  = level && !edge_prev_r;
    cap   = latch_mode ? clet_pkg::LIMIT_LATCH : cfg.trip_limit;

    episodes_nxt  = (rise && (episodes_r < cap)) ? episodes_r + 1'b1 : episodes_r;
    edge_prev_nxt = level;

    // timer state is frozen in latch mode
    tof_prev_nxt  = latch_mode ? tof_prev_r  : warning;
    tof_run_nxt   = latch_mode ? tof_run_r   : hold;
    tof_start_nxt = latch_mode ? tof_start_r : start0;

    res.episode_count = episodes_nxt;
    res.trip = latch_mode ? (episodes_nxt == clet_pkg::LIMIT_LATCH)
                          : (stretched || (episodes_nxt == cfg.trip_limit));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_prev_r <= 1'b0;
      episodes_r  <= '0;
      tof_prev_r  <= 1'b0;
      tof_run_r   <= 1'b0;
      tof_start_r <= '0;
    end else if (step) begin
      edge_prev_r <= edge_prev_nxt;
      episodes_r  <= episodes_nxt;
      tof_prev_r  <= tof_prev_nxt;
      tof_run_r   <= tof_run_nxt;
      tof_start_r <= tof_start_nxt;
    end
  end

endmodule

/* hdl/current_limit_episode_trip_top.sv */
`timescale 1ns / 1ps
// channel  | direction | payload                      | handshake
// in_chan  | sink      | warning, now_ms[31:0]        | valid / ready
// out_chan | source    | trip, episode_count[6:0]     | valid / ready
// cfg_*    | apb slave | off_delay_ms @0, limit @4    | psel / penable, pready tied high
//
// one word per cycle while out_chan.ready is high; input register, then result register
// the rate is set by the single state update between the input and result registers
// synchronous active-low reset clears timer, edge and episode state, cfg to defaults
// an input word is still taken while a result waits, until the input register fills

module current_limit_episode_trip_top (
  input  logic                        clk,
  input  logic                        rst_n,
  clet_in_if.sink                     in_chan,
  clet_out_if.source                  out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [clet_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [clet_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [clet_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  clet_pkg::clet_cfg_t    cfg;
  clet_pkg::clet_result_t res;

  // input register
  logic                       in_vld_r, in_vld_nxt;
  logic                       in_warn_r;
  logic [clet_pkg::NOW_W-1:0] in_now_r;

  // result register
  logic                       out_vld_r, out_vld_nxt;
  clet_pkg::clet_result_t     out_res_r;

  logic take;     // input word accepted
  logic advance;  // input register moves into result register

  clet_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // state advances exactly once per word, when it leaves the input register
  clet_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .warning (in_warn_r),
    .now_ms  (in_now_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign advance       = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || advance;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    in_vld_nxt  = take || (in_vld_r && !advance);
    out_vld_nxt = advance || (out_vld_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      in_warn_r <= in_chan.warning;
      in_now_r  <= in_chan.now_ms;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.trip          = out_res_r.trip;
  assign out_chan.episode_count = out_res_r.episode_count;

endmodule

/* hdl/clet_checker.sv */
`timescale 1ns / 1ps

module clet_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_trip,
  input logic [clet_pkg::CNT_W-1:0] out_episode_count
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_trip) && $stable(out_episode_count))
    else $error("result word changed while stalled");

  // with no result pending the pipeline can always take a word
  a_ready_when_empty: assert property (@(posedge clk)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // an accepted word is expected to reach the result register by way of the input register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("accepted word did not produce a result");

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind current_limit_episode_trip_top clet_checker u_clet_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_trip          (out_chan.trip),
  .out_episode_count (out_chan.episode_count)
);
